@@ design/rsas_pkg.sv @@
package rsas_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int VAL_W     = 32;
  localparam int FUNC_W    = 2;
  localparam int POS_W     = 10;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_SEARCH = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  // Microprogram addresses.
  typedef enum logic [4:0] {
    S_IDLE   = 5'd0,
    S_CHK3   = 5'd1,
    S_SCAN   = 5'd2,
    S_SCAN_W = 5'd3,
    S_SCAN_T = 5'd4,
    S_PV     = 5'd5,
    S_PV_M0  = 5'd6,
    S_PV_MN  = 5'd7,
    S_PV_R1  = 5'd8,
    S_PV_R2  = 5'd9,
    S_PV_R3  = 5'd10,
    S_PV_R4  = 5'd11,
    S_PV_T1  = 5'd12,
    S_PV_T2  = 5'd13,
    S_PV_T3  = 5'd14,
    S_PD     = 5'd15,
    S_PD_R1  = 5'd16,
    S_PD_R2  = 5'd17,
    S_PD_T   = 5'd18,
    S_BS     = 5'd19,
    S_BS_W   = 5'd20,
    S_BS_T1  = 5'd21,
    S_BS_T2  = 5'd22,
    S_EMIT   = 5'd23
  } step_t;

  typedef enum logic [3:0] {
    C_TRUE     = 4'd0,
    C_START    = 4'd1,
    C_NLT3     = 4'd2,
    C_LO_GE_N  = 4'd3,
    C_LO_GT_HI = 4'd4,
    C_MID0     = 4'd5,
    C_MIDN     = 4'd6,
    C_LMIN     = 4'd7,
    C_LMAX     = 4'd8,
    C_C_GT_H   = 4'd9,
    C_PIV_NEG  = 4'd10,
    C_IN_LEFT  = 4'd11,
    C_C_EQ_T   = 4'd12,
    C_C_GT_T   = 4'd13,
    C_OUT_FREE = 4'd14
  } cond_t;

  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_INIT      = 4'd1,
    OP_LO_INC    = 4'd2,
    OP_LO_MID1   = 4'd3,
    OP_HI_MIDM1  = 4'd4,
    OP_PIV_MID   = 4'd5,
    OP_PIV_MID1  = 4'd6,
    OP_SET_ALL   = 4'd7,
    OP_SET_LEFT  = 4'd8,
    OP_SET_RIGHT = 4'd9,
    OP_FOUND_LO  = 4'd10,
    OP_FOUND_MID = 4'd11,
    OP_NOT_FOUND = 4'd12,
    OP_EMIT      = 4'd13
  } op_t;

  typedef enum logic [2:0] {
    A_MID   = 3'd0,
    A_MIDM1 = 3'd1,
    A_MIDP1 = 3'd2,
    A_HI    = 3'd3,
    A_LO    = 3'd4,
    A_ZERO  = 3'd5,
    A_PIVM1 = 3'd6
  } asel_t;

  typedef enum logic [2:0] {
    L_NONE = 3'd0,
    L_C    = 3'd1,
    L_P    = 3'd2,
    L_Q    = 3'd3,
    L_H    = 3'd4
  } lsel_t;

  // One word of the control store.
  typedef struct packed {
    cond_t cond;
    step_t nxt_hit;
    step_t nxt_miss;
    op_t   op_hit;
    op_t   op_miss;
    asel_t asel;
    lsel_t lsel;
  } uword_t;

  // Controls that reach the datapath in the current step.
  typedef struct packed {
    op_t   op;
    asel_t asel;
    lsel_t lsel;
  } uctl_t;

  // Datapath flags tested by the sequencer.
  typedef struct packed {
    logic nlt3;
    logic lo_ge_n;
    logic lo_gt_hi;
    logic mid0;
    logic midn;
    logic lmin;
    logic lmax;
    logic c_gt_h;
    logic piv_neg;
    logic in_left;
    logic c_eq_t;
    logic c_gt_t;
  } dstat_t;

endpackage

@@ design/rsas_seq.sv @@
module rsas_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            out_free,
  input  rsas_pkg::dstat_t stat,
  output rsas_pkg::uctl_t  uctl,
  output logic            idle
);

  rsas_pkg::step_t  step_r;
  rsas_pkg::step_t  step_nxt;
  rsas_pkg::uword_t word;
  logic             hit;

  function automatic rsas_pkg::uword_t uw(
    input rsas_pkg::cond_t c,
    input rsas_pkg::step_t nh,
    input rsas_pkg::step_t nm,
    input rsas_pkg::op_t   oh,
    input rsas_pkg::op_t   om,
    input rsas_pkg::asel_t a,
    input rsas_pkg::lsel_t l
  );
    rsas_pkg::uword_t w;
    w.cond     = c;
    w.nxt_hit  = nh;
    w.nxt_miss = nm;
    w.op_hit   = oh;
    w.op_miss  = om;
    w.asel     = a;
    w.lsel     = l;
    return w;
  endfunction

  // Control store. A read issued in one step lands in the read register during
  // the next step, where the latch field captures it.
  always_comb begin
    case (step_r)
      rsas_pkg::S_IDLE: word = uw(rsas_pkg::C_START, rsas_pkg::S_CHK3, rsas_pkg::S_IDLE,
                                  rsas_pkg::OP_INIT, rsas_pkg::OP_NONE,
                                  rsas_pkg::A_MID, rsas_pkg::L_NONE);
      rsas_pkg::S_CHK3: word = uw(rsas_pkg::C_NLT3, rsas_pkg::S_SCAN, rsas_pkg::S_PV,
                                  rsas_pkg::OP_NONE, rsas_pkg::OP_NONE,
                                  rsas_pkg::A_MID, rsas_pkg::L_NONE);
      rsas_pkg::S_SCAN: word = uw(rsas_pkg::C_LO_GE_N, rsas_pkg::S_EMIT, rsas_pkg::S_SCAN_W,
                                  rsas_pkg::OP_NOT_FOUND, rsas_pkg::OP_NONE,
                                  rsas_pkg::A_LO, rsas_pkg::L_NONE);
      rsas_pkg::S_SCAN_W: word = uw(rsas_pkg::C_TRUE, rsas_pkg::S_SCAN_T, rsas_pkg::S_SCAN_T,
                                    rsas_pkg::OP_NONE, rsas_pkg::OP_NONE,
                                    rsas_pkg::A_MID, rsas_pkg::L_C);
      rsas_pkg::S_SCAN_T: word = uw(rsas_pkg::C_C_EQ_T, rsas_pkg::S_EMIT, rsas_pkg::S_SCAN,
                                    rsas_pkg::OP_FOUND_LO, rsas_pkg::OP_LO_INC,
                                    rsas_pkg::A_MID, rsas_pkg::L_NONE);
      rsas_pkg::S_PV: word = uw(rsas_pkg::C_LO_GT_HI, rsas_pkg::S_PD, rsas_pkg::S_PV_M0,
                                rsas_pkg::OP_NONE, rsas_pkg::OP_NONE,
                                rsas_pkg::A_MID, rsas_pkg::L_NONE);
      rsas_pkg::S_PV_M0: word = uw(rsas_pkg::C_MID0, rsas_pkg::S_PV, rsas_pkg::S_PV_MN,
                                   rsas_pkg::OP_LO_MID1, rsas_pkg::OP_NONE,
                                   rsas_pkg::A_MID, rsas_pkg::L_NONE);
      rsas_pkg::S_PV_MN: word = uw(rsas_pkg::C_MIDN, rsas_pkg::S_PV, rsas_pkg::S_PV_R1,
                                   rsas_pkg::OP_HI_MIDM1, rsas_pkg::OP_NONE,
                                   rsas_pkg::A_MID, rsas_pkg::L_NONE);
      rsas_pkg::S_PV_R1: word = uw(rsas_pkg::C_TRUE, rsas_pkg::S_PV_R2, rsas_pkg::S_PV_R2,
                                   rsas_pkg::OP_NONE, rsas_pkg::OP_NONE,
                                   rsas_pkg::A_MIDM1, rsas_pkg::L_C);
      rsas_pkg::S_PV_R2: word = uw(rsas_pkg::C_TRUE, rsas_pkg::S_PV_R3, rsas_pkg::S_PV_R3,
                                   rsas_pkg::OP_NONE, rsas_pkg::OP_NONE,
                                   rsas_pkg::A_MIDP1, rsas_pkg::L_P);
      rsas_pkg::S_PV_R3: word = uw(rsas_pkg::C_TRUE, rsas_pkg::S_PV_R4, rsas_pkg::S_PV_R4,
                                   rsas_pkg::OP_NONE, rsas_pkg::OP_NONE,
                                   rsas_pkg::A_HI, rsas_pkg::L_Q);
      rsas_pkg::S_PV_R4: word = uw(rsas_pkg::C_TRUE, rsas_pkg::S_PV_T1, rsas_pkg::S_PV_T1,
                                   rsas_pkg::OP_NONE, rsas_pkg::OP_NONE,
                                   rsas_pkg::A_MID, rsas_pkg::L_H);
      rsas_pkg::S_PV_T1: word = uw(rsas_pkg::C_LMIN, rsas_pkg::S_PD, rsas_pkg::S_PV_T2,
                                   rsas_pkg::OP_PIV_MID, rsas_pkg::OP_NONE,
                                   rsas_pkg::A_MID, rsas_pkg::L_NONE);
      rsas_pkg::S_PV_T2: word = uw(rsas_pkg::C_LMAX, rsas_pkg::S_PD, rsas_pkg::S_PV_T3,
                                   rsas_pkg::OP_PIV_MID1, rsas_pkg::OP_NONE,
                                   rsas_pkg::A_MID, rsas_pkg::L_NONE);
      rsas_pkg::S_PV_T3: word = uw(rsas_pkg::C_C_GT_H, rsas_pkg::S_PV, rsas_pkg::S_PV,
                                   rsas_pkg::OP_LO_MID1, rsas_pkg::OP_HI_MIDM1,
                                   rsas_pkg::A_MID, rsas_pkg::L_NONE);
      rsas_pkg::S_PD: word = uw(rsas_pkg::C_PIV_NEG, rsas_pkg::S_BS, rsas_pkg::S_PD_R1,
                                rsas_pkg::OP_SET_ALL, rsas_pkg::OP_NONE,
                                rsas_pkg::A_ZERO, rsas_pkg::L_NONE);
      rsas_pkg::S_PD_R1: word = uw(rsas_pkg::C_TRUE, rsas_pkg::S_PD_R2, rsas_pkg::S_PD_R2,
                                   rsas_pkg::OP_NONE, rsas_pkg::OP_NONE,
                                   rsas_pkg::A_PIVM1, rsas_pkg::L_P);
      rsas_pkg::S_PD_R2: word = uw(rsas_pkg::C_TRUE, rsas_pkg::S_PD_T, rsas_pkg::S_PD_T,
                                   rsas_pkg::OP_NONE, rsas_pkg::OP_NONE,
                                   rsas_pkg::A_MID, rsas_pkg::L_Q);
      rsas_pkg::S_PD_T: word = uw(rsas_pkg::C_IN_LEFT, rsas_pkg::S_BS, rsas_pkg::S_BS,
                                  rsas_pkg::OP_SET_LEFT, rsas_pkg::OP_SET_RIGHT,
                                  rsas_pkg::A_MID, rsas_pkg::L_NONE);
      rsas_pkg::S_BS: word = uw(rsas_pkg::C_LO_GT_HI, rsas_pkg::S_EMIT, rsas_pkg::S_BS_W,
                                rsas_pkg::OP_NOT_FOUND, rsas_pkg::OP_NONE,
                                rsas_pkg::A_MID, rsas_pkg::L_NONE);
      rsas_pkg::S_BS_W: word = uw(rsas_pkg::C_TRUE, rsas_pkg::S_BS_T1, rsas_pkg::S_BS_T1,
                                  rsas_pkg::OP_NONE, rsas_pkg::OP_NONE,
                                  rsas_pkg::A_MID, rsas_pkg::L_C);
      rsas_pkg::S_BS_T1: word = uw(rsas_pkg::C_C_EQ_T, rsas_pkg::S_EMIT, rsas_pkg::S_BS_T2,
                                   rsas_pkg::OP_FOUND_MID, rsas_pkg::OP_NONE,
                                   rsas_pkg::A_MID, rsas_pkg::L_NONE);
      rsas_pkg::S_BS_T2: word = uw(rsas_pkg::C_C_GT_T, rsas_pkg::S_BS, rsas_pkg::S_BS,
                                   rsas_pkg::OP_HI_MIDM1, rsas_pkg::OP_LO_MID1,
                                   rsas_pkg::A_MID, rsas_pkg::L_NONE);
      rsas_pkg::S_EMIT: word = uw(rsas_pkg::C_OUT_FREE, rsas_pkg::S_IDLE, rsas_pkg::S_EMIT,
                                  rsas_pkg::OP_EMIT, rsas_pkg::OP_NONE,
                                  rsas_pkg::A_MID, rsas_pkg::L_NONE);
      default: word = uw(rsas_pkg::C_TRUE, rsas_pkg::S_IDLE, rsas_pkg::S_IDLE,
                         rsas_pkg::OP_NONE, rsas_pkg::OP_NONE,
                         rsas_pkg::A_MID, rsas_pkg::L_NONE);
    endcase
  end

  always_comb begin
    case (word.cond)
      rsas_pkg::C_TRUE:     hit = 1'b1;
      rsas_pkg::C_START:    hit = start;
      rsas_pkg::C_NLT3:     hit = stat.nlt3;
      rsas_pkg::C_LO_GE_N:  hit = stat.lo_ge_n;
      rsas_pkg::C_LO_GT_HI: hit = stat.lo_gt_hi;
      rsas_pkg::C_MID0:     hit = stat.mid0;
      rsas_pkg::C_MIDN:     hit = stat.midn;
      rsas_pkg::C_LMIN:     hit = stat.lmin;
      rsas_pkg::C_LMAX:     hit = stat.lmax;
      rsas_pkg::C_C_GT_H:   hit = stat.c_gt_h;
      rsas_pkg::C_PIV_NEG:  hit = stat.piv_neg;
      rsas_pkg::C_IN_LEFT:  hit = stat.in_left;
      rsas_pkg::C_C_EQ_T:   hit = stat.c_eq_t;
      rsas_pkg::C_C_GT_T:   hit = stat.c_gt_t;
      rsas_pkg::C_OUT_FREE: hit = out_free;
      default:              hit = 1'b0;
    endcase
  end

  assign step_nxt  = hit ? word.nxt_hit : word.nxt_miss;
  assign uctl.op   = hit ? word.op_hit : word.op_miss;
  assign uctl.asel = word.asel;
  assign uctl.lsel = word.lsel;
  assign idle      = (step_r == rsas_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= rsas_pkg::S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

@@ design/rsas_dp.sv @@
module rsas_dp #(
  parameter int DEPTH = rsas_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rsas_pkg::uctl_t                   uctl,
  input  logic                              clear,
  input  logic                              append,
  input  logic signed [rsas_pkg::VAL_W-1:0] in_value,
  output rsas_pkg::dstat_t                  stat,
  output logic                              res_found,
  output logic [rsas_pkg::POS_W-1:0]        res_pos
);

  localparam int VW = rsas_pkg::VAL_W;
  localparam int PW = rsas_pkg::POS_W;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = CW + 1;
  localparam logic signed [IW-1:0] ONE = IW'(1);

  logic signed [VW-1:0] mem [DEPTH];
  logic signed [VW-1:0] rd_r;
  logic signed [VW-1:0] c_r, p_r, q_r, h_r, t_r;
  logic [CW-1:0]        count_r;
  logic signed [IW-1:0] lo_r, hi_r, piv_r;
  logic                 res_found_r;
  logic [PW-1:0]        res_pos_r;

  logic [IW:0]          msum;
  logic signed [IW-1:0] mid;
  logic signed [IW-1:0] n_s;
  logic signed [IW-1:0] idx;
  logic [AW-1:0]        rd_addr;
  logic                 can_append;

  // lo never exceeds hi where mid is used, so the sum is non-negative.
  assign msum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid  = signed'(msum[IW:1]);
  assign n_s  = signed'({1'b0, count_r});

  always_comb begin
    case (uctl.asel)
      rsas_pkg::A_MID:   idx = mid;
      rsas_pkg::A_MIDM1: idx = mid - ONE;
      rsas_pkg::A_MIDP1: idx = mid + ONE;
      rsas_pkg::A_HI:    idx = hi_r;
      rsas_pkg::A_LO:    idx = lo_r;
      rsas_pkg::A_ZERO:  idx = '0;
      rsas_pkg::A_PIVM1: idx = piv_r - ONE;
      default:           idx = '0;
    endcase
  end

  assign rd_addr    = idx[AW-1:0];
  assign can_append = (32'(count_r) < DEPTH);

  always_ff @(posedge clk) begin
    if (append && can_append) begin
      mem[count_r[AW-1:0]] <= in_value;
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (clear) begin
      count_r <= '0;
    end else if (append && can_append) begin
      count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (uctl.lsel)
      rsas_pkg::L_C:    c_r <= rd_r;
      rsas_pkg::L_P:    p_r <= rd_r;
      rsas_pkg::L_Q:    q_r <= rd_r;
      rsas_pkg::L_H:    h_r <= rd_r;
      default:          ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (uctl.op)
      rsas_pkg::OP_INIT: begin
        t_r   <= in_value;
        lo_r  <= '0;
        hi_r  <= n_s - ONE;
        piv_r <= -ONE;
      end
      rsas_pkg::OP_LO_INC:   lo_r  <= lo_r + ONE;
      rsas_pkg::OP_LO_MID1:  lo_r  <= mid + ONE;
      rsas_pkg::OP_HI_MIDM1: hi_r  <= mid - ONE;
      rsas_pkg::OP_PIV_MID:  piv_r <= mid;
      rsas_pkg::OP_PIV_MID1: piv_r <= mid + ONE;
      rsas_pkg::OP_SET_ALL: begin
        lo_r <= '0;
        hi_r <= n_s - ONE;
      end
      rsas_pkg::OP_SET_LEFT: begin
        lo_r <= '0;
        hi_r <= piv_r - ONE;
      end
      rsas_pkg::OP_SET_RIGHT: begin
        lo_r <= piv_r;
        hi_r <= n_s - ONE;
      end
      rsas_pkg::OP_FOUND_LO: begin
        res_found_r <= 1'b1;
        res_pos_r   <= PW'($unsigned(lo_r));
      end
      rsas_pkg::OP_FOUND_MID: begin
        res_found_r <= 1'b1;
        res_pos_r   <= PW'($unsigned(mid));
      end
      rsas_pkg::OP_NOT_FOUND: begin
        res_found_r <= 1'b0;
        res_pos_r   <= '0;
      end
      default: ;
    endcase
  end

  assign stat.nlt3     = (32'(count_r) < 32'd3);
  assign stat.lo_ge_n  = (lo_r >= n_s);
  assign stat.lo_gt_hi = (lo_r > hi_r);
  assign stat.mid0     = (mid == '0);
  assign stat.midn     = (mid == n_s - ONE);
  assign stat.lmin     = (c_r < p_r) && (c_r < q_r);
  assign stat.lmax     = (c_r > p_r) && (c_r > q_r);
  assign stat.c_gt_h   = (c_r > h_r);
  assign stat.piv_neg  = piv_r[IW-1];
  // p holds the first element and q the one just before the pivot here.
  assign stat.in_left  = (t_r >= p_r) && (t_r <= q_r);
  assign stat.c_eq_t   = (c_r == t_r);
  assign stat.c_gt_t   = (c_r > t_r);

  assign res_found = res_found_r;
  assign res_pos   = res_pos_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= DEPTH)
    else $error("element count exceeds store depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    clear |=> (count_r == '0))
    else $error("clear request did not empty the store");
`endif

endmodule

@@ design/rotated_sorted_array_search_top.sv @@
// Search in a rotated sorted array of signed 32-bit values.
// Input channel (in_valid/in_ready, in_func, in_value): a request either
// clears the store, appends in_value at the end (ignored when full) or
// searches for in_value. Unused function codes are dropped.
// Clear and append give no result.
// A search gives one result on the output channel (out_valid/out_ready,
// out_found, out_position); out_position is zero when nothing is found.
// Searches are run by a microcoded sequencer over a store with one read port.
// With fewer than three elements, a linear scan checks the elements in order.
// Otherwise a pivot search finds the rotation point and a binary search then
// runs over the part of the store that can hold the value.
// Only one search is in flight at a time.
// The result sits in an output register; when the receiver stalls, the block
// still takes clear and append requests, and a second search finishes only once
// the pending result is taken.
// Reset empties the store and drops any pending result; store contents are
// not cleared, only the element count.
module rotated_sorted_array_search_top #(
  parameter int DEPTH = rsas_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rsas_pkg::FUNC_W-1:0]       in_func,
  input  logic signed [rsas_pkg::VAL_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_found,
  output logic [rsas_pkg::POS_W-1:0]        out_position
);

  rsas_pkg::uctl_t           uctl;
  rsas_pkg::dstat_t          stat;
  logic                      idle;
  logic                      start;
  logic                      out_free;
  logic                      in_take;
  logic                      res_found;
  logic [rsas_pkg::POS_W-1:0] res_pos;
  logic                      out_valid_r;
  logic                      out_found_r;
  logic [rsas_pkg::POS_W-1:0] out_position_r;

  assign in_ready = idle;
  assign in_take  = in_valid && in_ready;
  assign start    = in_valid && (in_func == rsas_pkg::FUNC_SEARCH);
  assign out_free = !out_valid_r || out_ready;

  rsas_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_free (out_free),
    .stat     (stat),
    .uctl     (uctl),
    .idle     (idle)
  );

  rsas_dp #(.DEPTH(DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .uctl      (uctl),
    .clear     (in_take && (in_func == rsas_pkg::FUNC_CLEAR)),
    .append    (in_take && (in_func == rsas_pkg::FUNC_APPEND)),
    .in_value  (in_value),
    .stat      (stat),
    .res_found (res_found),
    .res_pos   (res_pos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (uctl.op == rsas_pkg::OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uctl.op == rsas_pkg::OP_EMIT) begin
      out_found_r    <= res_found;
      out_position_r <= res_pos;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;

`ifndef ASSERT_OFF
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (uctl.op == rsas_pkg::OP_EMIT) |-> out_free)
    else $error("result written over one not yet taken");

  a_search_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && (in_func == rsas_pkg::FUNC_SEARCH)) |=> !idle)
    else $error("search request did not start the sequencer");

  a_miss_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_position_r == '0))
    else $error("position not zero on a miss");

  a_emit_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    idle |-> (uctl.op != rsas_pkg::OP_EMIT))
    else $error("result issued while idle");
`endif

endmodule

@@ bench/rsas_result_checker.sv @@
module rsas_result_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [rsas_pkg::FUNC_W-1:0]       in_func,
  input  logic signed [rsas_pkg::VAL_W-1:0] in_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              out_found,
  input  logic [rsas_pkg::POS_W-1:0]        out_position,
  output int                                fail_count,
  output int                                pending,
  output int                                searches,
  output int                                hits
);

  localparam int DEPTH = rsas_pkg::DEPTH_DEF;

  typedef struct packed {
    logic                       found;
    logic [rsas_pkg::POS_W-1:0] position;
  } lookup_t;

  logic signed [rsas_pkg::VAL_W-1:0] mirror [DEPTH];
  int                                mirror_len;
  lookup_t                           pending_lookups [$];

  task automatic report_mismatch(input string what);
    if (fail_count < 40) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
    fail_count++;
  endtask

  function automatic int bin_lookup(int lo, int hi, logic signed [rsas_pkg::VAL_W-1:0] t);
    int mid;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (mirror[mid] == t) return mid;
      if (mirror[mid] > t) hi = mid - 1;
      else lo = mid + 1;
    end
    return -1;
  endfunction

  // Returns the index the block should report, or -1 when it should miss.
  function automatic int locate(logic signed [rsas_pkg::VAL_W-1:0] t);
    int n;
    int lo;
    int hi;
    int mid;
    int pivot;
    logic signed [rsas_pkg::VAL_W-1:0] c;
    logic signed [rsas_pkg::VAL_W-1:0] p;
    logic signed [rsas_pkg::VAL_W-1:0] q;
    n = mirror_len;
    lo = 0;
    hi = n - 1;
    pivot = -1;
    if (n < 3) begin
      for (int i = 0; i < n; i++) begin
        if (mirror[i] == t) return i;
      end
      return -1;
    end
    // The first probe that is a local minimum or maximum fixes the rotation point.
    while (lo <= hi && pivot < 0) begin
      mid = lo + (hi - lo) / 2;
      if (mid == 0) begin
        lo = mid + 1;
      end else if (mid == n - 1) begin
        hi = mid - 1;
      end else begin
        c = mirror[mid];
        p = mirror[mid - 1];
        q = mirror[mid + 1];
        if (c < p && c < q) pivot = mid;
        else if (c > p && c > q) pivot = mid + 1;
        else if (c > mirror[hi]) lo = mid + 1;
        else hi = mid - 1;
      end
    end
    if (pivot < 0) return bin_lookup(0, n - 1, t);
    if (t >= mirror[0] && t <= mirror[pivot - 1]) return bin_lookup(0, pivot - 1, t);
    return bin_lookup(pivot, n - 1, t);
  endfunction

  always @(posedge clk) begin : watch
    lookup_t want;
    int      idx;
    if (!rst_n) begin
      mirror_len = 0;
      pending_lookups.delete();
      fail_count = 0;
      searches   = 0;
      hits       = 0;
      pending   <= 0;
    end else begin
      // Results first, so a result can never be matched against a request taken
      // at the same edge.
      if (out_valid && out_ready) begin
        if (pending_lookups.size() == 0) begin
          report_mismatch($sformatf("result found=%0b position=%0d with no search outstanding",
                                    out_found, out_position));
        end else begin
          want = pending_lookups.pop_front();
          if (out_found !== want.found) begin
            report_mismatch($sformatf("found is %0b, expected %0b", out_found, want.found));
          end
          if (out_position !== want.position) begin
            report_mismatch($sformatf("position is %0d, expected %0d",
                                      out_position, want.position));
          end
          if (want.found) hits++;
        end
      end
      if (in_valid && in_ready) begin
        case (rsas_pkg::func_t'(in_func))
          rsas_pkg::FUNC_CLEAR: mirror_len = 0;
          rsas_pkg::FUNC_APPEND: begin
            if (mirror_len < DEPTH) begin
              mirror[mirror_len] = in_value;
              mirror_len++;
            end
          end
          rsas_pkg::FUNC_SEARCH: begin
            idx = locate(in_value);
            want.found    = (idx >= 0);
            want.position = (idx >= 0) ? idx[rsas_pkg::POS_W-1:0] : '0;
            pending_lookups.push_back(want);
            searches++;
          end
          default: ;
        endcase
      end
      pending <= pending_lookups.size();
    end
  end

endmodule

@@ bench/rotated_sorted_array_search_top_test.sv @@
module rotated_sorted_array_search_top_test;

  localparam int DEPTH        = rsas_pkg::DEPTH_DEF;
  localparam int VW           = rsas_pkg::VAL_W;
  localparam int ITEM_TARGET  = 1550;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 400;

  localparam logic signed [VW-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VW-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [rsas_pkg::FUNC_W-1:0]  in_func;
  logic signed [VW-1:0]         in_value;
  logic                         out_valid;
  logic                         out_ready;
  logic                         out_found;
  logic [rsas_pkg::POS_W-1:0]   out_position;

  int fail_count;
  int pending;
  int searches;
  int hits;

  int  items_sent  = 0;
  int  stored      = 0;
  int  cycle_count = 0;
  int  rx_hold     = 0;
  bit  rx_eager    = 1'b0;
  bit  settle_tail = 1'b0;
  bit  tx_gappy    = 1'b1;
  bit  full_done   = 1'b0;

  // Ascending values of the current set, before rotation.
  logic signed [VW-1:0] asc [$];

  rotated_sorted_array_search_top #(.DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_found    (out_found),
    .out_position (out_position)
  );

  rsas_result_checker result_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_found    (out_found),
    .out_position (out_position),
    .fail_count   (fail_count),
    .pending      (pending),
    .searches     (searches),
    .hits         (hits)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, pending);
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver pacing: random stall bursts, with calm stretches.
  always @(posedge clk) begin : rx_pacing
    if ($urandom_range(0, 299) == 0) rx_eager = !rx_eager;
    if (!rst_n || settle_tail || rx_eager) begin
      out_ready <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      rx_hold = $urandom_range(1, 14) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_req(input rsas_pkg::func_t f, input logic signed [VW-1:0] v);
    int gap;
    if (!settle_tail && tx_gappy && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= f;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Unused codes and appends to a full store do nothing, so they are not counted.
    case (f)
      rsas_pkg::FUNC_CLEAR: begin
        stored = 0;
        items_sent++;
      end
      rsas_pkg::FUNC_APPEND: begin
        if (stored < DEPTH) begin
          stored++;
          items_sent++;
        end
      end
      rsas_pkg::FUNC_SEARCH: items_sent++;
      default: ;
    endcase
  endtask

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 12);
    if (r < 9) return $urandom_range(13, 64);
    return $urandom_range(65, 300);
  endfunction

  // Distinct ascending values: either spread over the whole range or packed tight.
  task automatic fill_ascending(input int n);
    longint      acc;
    longint      stride_l;
    int unsigned stride;
    asc.delete();
    if (n > 0) begin
      if ($urandom_range(0, 3) == 0) begin
        stride = $urandom_range(1, 8);
        acc    = longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824;
      end else begin
        stride_l = 64'sd4294967296 / (n + 1);
        stride   = stride_l[31:0];
        acc      = -64'sd2147483648 + longint'($urandom_range(0, stride - 1));
      end
      asc.push_back(acc[31:0]);
      for (int i = 1; i < n; i++) begin
        acc = acc + longint'($urandom_range(1, stride));
        asc.push_back(acc[31:0]);
      end
    end
  endtask

  function automatic logic signed [VW-1:0] pick_target();
    int r;
    int j;
    r = $urandom_range(0, 9);
    if (asc.size() > 0) j = $urandom_range(0, asc.size() - 1);
    if (asc.size() > 0 && r < 6) return asc[j];
    if (asc.size() > 0 && r < 8) return $urandom_range(0, 1) ? asc[j] + 1 : asc[j] - 1;
    if (r == 8) return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
    return $urandom;
  endfunction

  // Loads a rotated ascending set (after a clear when fresh) and searches it.
  // A mangled set carries a duplicate or an out-of-order value.
  task automatic run_rotated_set(input int n, input bit fresh, input bit mangle);
    logic signed [VW-1:0] rot [$];
    int shift;
    int j;
    int lookups;
    fill_ascending(n);
    shift = 0;
    if (n > 0 && $urandom_range(0, 4) != 0) shift = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) rot.push_back(asc[(i + shift) % n]);
    if (mangle && n > 1) begin
      j = $urandom_range(0, n - 1);
      rot[j] = $urandom_range(0, 1) ? rot[(j + 1) % n] : $urandom;
    end
    if (fresh) send_req(rsas_pkg::FUNC_CLEAR, $urandom);
    foreach (rot[i]) send_req(rsas_pkg::FUNC_APPEND, rot[i]);
    if (n == DEPTH) begin
      repeat (2) send_req(rsas_pkg::FUNC_APPEND, $urandom);
      send_req(rsas_pkg::FUNC_SEARCH, asc[0]);
      send_req(rsas_pkg::FUNC_SEARCH, asc[DEPTH - 1]);
      send_req(rsas_pkg::FUNC_SEARCH, rot[DEPTH - 1]);
      lookups = 8;
    end else begin
      lookups = $urandom_range(2, 8);
    end
    repeat (lookups) send_req(rsas_pkg::FUNC_SEARCH, pick_target());
  endtask

  task automatic run_noise();
    int                   m;
    rsas_pkg::func_t      f;
    logic signed [VW-1:0] last;
    m    = $urandom_range(3, 20);
    last = $urandom;
    repeat (m) begin
      case ($urandom_range(0, 9))
        0:       f = rsas_pkg::FUNC_CLEAR;
        1:       f = rsas_pkg::FUNC_NOP;
        2, 3, 4: f = rsas_pkg::FUNC_SEARCH;
        default: f = rsas_pkg::FUNC_APPEND;
      endcase
      if ($urandom_range(0, 2) != 0) last = $urandom;
      send_req(f, last);
    end
  endtask

  initial begin : stimulus
    int pick;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_func  = rsas_pkg::FUNC_CLEAR;
    in_value = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty store, unused code, and the linear scan at one and two elements.
    send_req(rsas_pkg::FUNC_SEARCH, 32'sd0);
    send_req(rsas_pkg::FUNC_NOP, VAL_MAX);
    send_req(rsas_pkg::FUNC_APPEND, VAL_MIN);
    send_req(rsas_pkg::FUNC_SEARCH, VAL_MIN);
    send_req(rsas_pkg::FUNC_SEARCH, VAL_MAX);
    send_req(rsas_pkg::FUNC_APPEND, VAL_MAX);
    send_req(rsas_pkg::FUNC_SEARCH, VAL_MAX);
    send_req(rsas_pkg::FUNC_SEARCH, -32'sd1);
    send_req(rsas_pkg::FUNC_CLEAR, -32'sd1);
    send_req(rsas_pkg::FUNC_SEARCH, VAL_MIN);
    // A small rotated set: the pivot, both halves, and a miss.
    send_req(rsas_pkg::FUNC_APPEND, 32'sd10);
    send_req(rsas_pkg::FUNC_APPEND, 32'sd20);
    send_req(rsas_pkg::FUNC_APPEND, -32'sd30);
    send_req(rsas_pkg::FUNC_APPEND, -32'sd5);
    send_req(rsas_pkg::FUNC_APPEND, 32'sd0);
    send_req(rsas_pkg::FUNC_SEARCH, -32'sd30);
    send_req(rsas_pkg::FUNC_SEARCH, 32'sd20);
    send_req(rsas_pkg::FUNC_SEARCH, 32'sd0);
    send_req(rsas_pkg::FUNC_SEARCH, 32'sd15);
    // All values equal.
    send_req(rsas_pkg::FUNC_CLEAR, 32'sd0);
    send_req(rsas_pkg::FUNC_APPEND, 32'sd7);
    send_req(rsas_pkg::FUNC_APPEND, 32'sd7);
    send_req(rsas_pkg::FUNC_APPEND, 32'sd7);
    send_req(rsas_pkg::FUNC_SEARCH, 32'sd7);

    while (items_sent < ITEM_TARGET) begin
      settle_tail = (items_sent > ITEM_TARGET * 9 / 10);
      tx_gappy    = ($urandom_range(0, 3) != 0);
      pick        = $urandom_range(0, 99);
      if (!full_done && items_sent > 250) begin
        run_rotated_set(DEPTH, 1'b1, 1'b0);
        full_done = 1'b1;
      end else if (pick < 72) begin
        run_rotated_set(pick_size(), 1'b1, 1'b0);
      end else if (pick < 84) begin
        run_rotated_set(pick_size(), $urandom_range(0, 1), 1'b1);
      end else begin
        run_noise();
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests; %0d searches checked, %0d of them hits.",
             items_sent, searches, hits);
    $display("Store sizes ran from empty to full, with overflow appends and mangled sets.");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ rotated_sorted_array_search_top.f @@
design/rsas_pkg.sv
design/rsas_seq.sv
design/rsas_dp.sv
design/rotated_sorted_array_search_top.sv
bench/rsas_result_checker.sv
bench/rotated_sorted_array_search_top_test.sv
